// ===== rtl/groc_pkg.sv =====
// shared types, constants and request codes for the grid occupancy map
package groc_pkg;

    // grid limits
    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;

    // field and internal widths
    localparam int FLD_W  = 5;
    localparam int OP_W   = 3;
    localparam int CRD_W  = 8;
    localparam int SZ_W   = CRD_W - 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = (MAX_ROWS >= 32) ? $clog2(MAX_ROWS + 1) : FLD_W;
    localparam int IDX_W  = 1;

    // request codes
    localparam logic [OP_W-1:0] OP_CHECK   = 3'd0;
    localparam logic [OP_W-1:0] OP_OCCUPY  = 3'd1;
    localparam logic [OP_W-1:0] OP_VACATE  = 3'd2;
    localparam logic [OP_W-1:0] OP_COPY    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESERVE = 3'd4;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd5;

    // register indexes
    localparam logic [IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [IDX_W-1:0] REG_GRID_COLS = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic finished;
        logic stop;
    } dp_status_t;

endpackage

// ===== rtl/groc_ctrl.sv =====
// request sequencer: accepts a request, steps rows, issues the done strobe
module groc_ctrl
    import groc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.finished || status.stop)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        busy     = 1'b1;
        done     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_RUN:
            begin
                cmd.step = !status.finished;
            end
            ST_FINISH:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/groc_datapath.sv =====
// datapath: grid size registers, both bitmaps and the per-row update logic
module groc_datapath
    import groc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [OP_W-1:0]   req_type,
    input  logic [FLD_W-1:0]  anchor_x,
    input  logic [FLD_W-1:0]  anchor_y,
    input  logic [FLD_W-1:0]  rect_rows,
    input  logic [FLD_W-1:0]  rect_cols,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_addr,
    input  logic [FLD_W-1:0]  cfg_wdata,
    output logic              blocked
);

    // size register write value: zero taken as one, large values saturated
    function automatic logic [SZ_W-1:0] clamp_size(input logic [FLD_W-1:0] v, input int maxv);
        logic [SZ_W-1:0] s;
        begin
            s = SZ_W'(v);
            if (v == '0)
            begin
                s = SZ_W'(1);
            end
            else if (int'(v) > maxv)
            begin
                s = SZ_W'(maxv);
            end
            return s;
        end
    endfunction

    logic [SZ_W-1:0]     grid_rows_reg;
    logic [SZ_W-1:0]     grid_cols_reg;
    logic [MAX_COLS-1:0] main_reg    [MAX_ROWS];
    logic [MAX_COLS-1:0] scratch_reg [MAX_ROWS];
    logic [CNT_W-1:0]    row_cnt_reg;
    logic [CNT_W-1:0]    limit_reg;
    logic                blocked_reg;

    // latched request
    logic [OP_W-1:0]     op_reg;
    logic [FLD_W-1:0]    ax_reg;
    logic [FLD_W-1:0]    ay_reg;
    logic [FLD_W-1:0]    nc_reg;

    logic [CNT_W-1:0]         limit_next;
    logic signed [CRD_W-1:0]  ax_s;
    logic signed [CRD_W-1:0]  end_s;
    logic signed [CRD_W-1:0]  r_s;
    logic signed [CRD_W-1:0]  gr_s;
    logic signed [CRD_W-1:0]  gc_s;
    logic signed [CRD_W-1:0]  cpos;
    logic [MAX_COLS-1:0]      col_mask;
    logic [MAX_COLS-1:0]      row_val;
    logic [MAX_COLS-1:0]      hit;
    logic [MAX_COLS-1:0]      hit_low;
    logic [MAX_COLS-1:0]      resv_mask;
    logic [ROW_W-1:0]         row_sel;
    logic [ROW_W-1:0]         copy_sel;
    logic                     row_ok;
    logic                     col_oob;
    logic                     is_probe;
    logic                     collide;

    // row count of the new request
    always_comb
    begin
        limit_next = '0;
        if (req_type == OP_COPY)
        begin
            limit_next = CNT_W'(MAX_ROWS);
        end
        else if ((req_type == OP_CHECK || req_type == OP_OCCUPY || req_type == OP_VACATE ||
                  req_type == OP_RESERVE || req_type == OP_RELEASE) && rect_cols != '0)
        begin
            limit_next = CNT_W'(rect_rows);
        end
    end

    // current row and column bounds
    always_comb
    begin
        ax_s     = CRD_W'($signed(ax_reg));
        end_s    = ax_s + $signed(CRD_W'(nc_reg));
        r_s      = CRD_W'($signed(ay_reg)) + $signed(CRD_W'(row_cnt_reg));
        gr_s     = $signed(CRD_W'(grid_rows_reg));
        gc_s     = $signed(CRD_W'(grid_cols_reg));
        row_ok   = (r_s >= $signed(CRD_W'(0))) && (r_s < gr_s);
        row_sel  = r_s[ROW_W-1:0];
        copy_sel = row_cnt_reg[ROW_W-1:0];
        col_oob  = (nc_reg != '0) && ((ax_s < $signed(CRD_W'(0))) || (end_s > gc_s));
    end

    // in-range columns of the rectangle
    always_comb
    begin
        col_mask = '0;
        cpos     = '0;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            cpos        = $signed(CRD_W'(c));
            col_mask[c] = (cpos >= ax_s) && (cpos < end_s) && (cpos < gc_s);
        end
    end

    // probe of the current row and the reserve prefix
    always_comb
    begin
        row_val   = (op_reg == OP_CHECK) ? main_reg[row_sel] : scratch_reg[row_sel];
        hit       = row_val & col_mask;
        hit_low   = hit & (~hit + MAX_COLS'(1));
        resv_mask = (hit != '0) ? (col_mask & (hit_low - MAX_COLS'(1))) : col_mask;
        is_probe  = (op_reg == OP_CHECK) || (op_reg == OP_RESERVE);
        collide   = !row_ok || col_oob || (hit != '0);
    end

    assign status.finished = (row_cnt_reg == limit_reg);
    assign status.stop     = is_probe && collide;
    assign blocked         = blocked_reg;

    // request fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= req_type;
            ax_reg <= anchor_x;
            ay_reg <= anchor_y;
            nc_reg <= rect_cols;
        end
    end

    // row counter and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            limit_reg   <= '0;
            blocked_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            row_cnt_reg <= '0;
            limit_reg   <= limit_next;
            blocked_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            row_cnt_reg <= row_cnt_reg + CNT_W'(1);
            if (is_probe && collide)
            begin
                blocked_reg <= 1'b1;
            end
        end
    end

    // grid size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= SZ_W'(1);
            grid_cols_reg <= SZ_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_GRID_ROWS: grid_rows_reg <= clamp_size(cfg_wdata, MAX_ROWS);
                REG_GRID_COLS: grid_cols_reg <= clamp_size(cfg_wdata, MAX_COLS);
                default:       grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    // bitmaps: cleared on reset and on any size write, one row updated per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                main_reg[i]    <= '0;
                scratch_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                main_reg[i]    <= '0;
                scratch_reg[i] <= '0;
            end
        end
        else if (cmd.step)
        begin
            if (op_reg == OP_COPY)
            begin
                scratch_reg[copy_sel] <= main_reg[copy_sel];
            end
            else if (row_ok)
            begin
                if (op_reg == OP_OCCUPY)
                begin
                    main_reg[row_sel] <= main_reg[row_sel] | col_mask;
                end
                else if (op_reg == OP_VACATE)
                begin
                    main_reg[row_sel] <= main_reg[row_sel] & ~col_mask;
                end
                else if (op_reg == OP_RELEASE)
                begin
                    scratch_reg[row_sel] <= scratch_reg[row_sel] & ~col_mask;
                end
                else if (op_reg == OP_RESERVE && ax_s >= $signed(CRD_W'(0)))
                begin
                    scratch_reg[row_sel] <= scratch_reg[row_sel] | resv_mask;
                end
            end
        end
    end

endmodule

// ===== rtl/grid_rectangle_occupancy_map_unit.sv =====
// top level of the grid rectangle occupancy map
//
//  channel   signals                                           direction
//  request   start, busy, req_type, anchor_x/y, rect_rows/cols  in (busy out)
//  result    done, blocked                                     out
//  config    cfg_wr_en, cfg_addr, cfg_wdata                    in
//
// done follows after one step per rectangle row (row count up to 31);
// zero columns or an unknown code run no row steps, a copy steps through
// all MAX_ROWS rows; check and reserve end early on a collision.
// busy drops in the cycle after done.
// the row loop reads, modifies and writes one bitmap row per cycle.
// reset clears both maps and sets the grid to one by one; a size write
// clears both maps in the same cycle.
// done is high for exactly one cycle; the receiver cannot stall it.
module grid_rectangle_occupancy_map_unit
    import groc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   req_type,
    input  logic [FLD_W-1:0]  anchor_x,
    input  logic [FLD_W-1:0]  anchor_y,
    input  logic [FLD_W-1:0]  rect_rows,
    input  logic [FLD_W-1:0]  rect_cols,
    output logic              done,
    output logic              blocked,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_addr,
    input  logic [FLD_W-1:0]  cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    groc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // maps and row logic
    groc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_type  (req_type),
        .anchor_x  (anchor_x),
        .anchor_y  (anchor_y),
        .rect_rows (rect_rows),
        .rect_cols (rect_cols),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .blocked   (blocked)
    );

endmodule

// ===== test/grid_rectangle_occupancy_map_unit_test.sv =====
// self-checking bench for the grid occupancy map: directed table, random requests, own map copy
module grid_rectangle_occupancy_map_unit_test;
    import groc_pkg::*;

    // request codes with no defined operation
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 8;
    localparam int PHASE_REQUESTS = 240;
    localparam int DIRECTED_ROWS = 26;

    // one row of the directed table
    typedef struct packed {
        logic             regrid;
        logic [FLD_W-1:0] grid_r;
        logic [FLD_W-1:0] grid_c;
        logic [OP_W-1:0]  op;
        logic [FLD_W-1:0] ax;
        logic [FLD_W-1:0] ay;
        logic [FLD_W-1:0] nr;
        logic [FLD_W-1:0] nc;
        logic             pinned;
        logic             pin_val;
    } step_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   req_type;
    logic [FLD_W-1:0]  anchor_x;
    logic [FLD_W-1:0]  anchor_y;
    logic [FLD_W-1:0]  rect_rows;
    logic [FLD_W-1:0]  rect_cols;
    logic              done;
    logic              blocked;
    logic              cfg_wr_en;
    logic [IDX_W-1:0]  cfg_addr;
    logic [FLD_W-1:0]  cfg_wdata;

    // typed-in expectation travelling with the request
    logic              pin_valid;
    logic              pin_value;

    // shadow of the grid and both maps
    logic [MAX_COLS-1:0] main_cells [MAX_ROWS];
    logic [MAX_COLS-1:0] scratch_cells [MAX_ROWS];
    int                  rows_used;
    int                  cols_used;

    logic                pending_blocked [$];
    int                  fail_count;
    int                  cycle_count;
    logic                idle_mode;

    step_row_t directed_steps [DIRECTED_ROWS] = '{
        // fresh one by one grid
        '{1'b0, 5'd0,  5'd0,  OP_CHECK,    5'd0,  5'd0,  5'd1,  5'd1,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_CHECK,    5'd0,  5'd0,  5'd0,  5'd0,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_CHECK,    5'd1,  5'd0,  5'd1,  5'd1,  1'b1, 1'b1},
        '{1'b0, 5'd0,  5'd0,  OP_CHECK,    5'd16, 5'd16, 5'd1,  5'd1,  1'b1, 1'b1},
        '{1'b0, 5'd0,  5'd0,  OP_OCCUPY,   5'd0,  5'd0,  5'd1,  5'd1,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_CHECK,    5'd0,  5'd0,  5'd1,  5'd1,  1'b1, 1'b1},
        '{1'b0, 5'd0,  5'd0,  OP_UNUSED_6, 5'd31, 5'd31, 5'd31, 5'd31, 1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_UNUSED_7, 5'd0,  5'd0,  5'd1,  5'd1,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_CHECK,    5'd0,  5'd0,  5'd1,  5'd1,  1'b1, 1'b1},
        // full grid, size write clears the maps
        '{1'b1, 5'd16, 5'd16, OP_CHECK,    5'd0,  5'd0,  5'd16, 5'd16, 1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_OCCUPY,   5'd0,  5'd0,  5'd16, 5'd16, 1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_CHECK,    5'd15, 5'd15, 5'd1,  5'd1,  1'b1, 1'b1},
        '{1'b0, 5'd0,  5'd0,  OP_VACATE,   5'd4,  5'd4,  5'd8,  5'd8,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_CHECK,    5'd4,  5'd4,  5'd8,  5'd8,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_CHECK,    5'd4,  5'd4,  5'd8,  5'd9,  1'b1, 1'b1},
        // scratch map reservations
        '{1'b0, 5'd0,  5'd0,  OP_COPY,     5'd0,  5'd0,  5'd0,  5'd0,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_RESERVE,  5'd4,  5'd4,  5'd2,  5'd2,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_RESERVE,  5'd4,  5'd4,  5'd1,  5'd1,  1'b1, 1'b1},
        '{1'b0, 5'd0,  5'd0,  OP_RELEASE,  5'd4,  5'd4,  5'd1,  5'd1,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_RESERVE,  5'd5,  5'd4,  5'd3,  5'd3,  1'b0, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_RESERVE,  5'd8,  5'd8,  5'd2,  5'd31, 1'b0, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_RELEASE,  5'd29, 5'd29, 5'd8,  5'd8,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_VACATE,   5'd16, 5'd16, 5'd31, 5'd31, 1'b1, 1'b0},
        // oversized rows and zero columns
        '{1'b1, 5'd31, 5'd0,  OP_CHECK,    5'd0,  5'd15, 5'd1,  5'd1,  1'b1, 1'b0},
        '{1'b0, 5'd0,  5'd0,  OP_CHECK,    5'd1,  5'd0,  5'd1,  5'd1,  1'b1, 1'b1},
        '{1'b0, 5'd0,  5'd0,  OP_RESERVE,  5'd0,  5'd0,  5'd16, 5'd1,  1'b1, 1'b0}
    };

    grid_rectangle_occupancy_map_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .anchor_x  (anchor_x),
        .anchor_y  (anchor_y),
        .rect_rows (rect_rows),
        .rect_cols (rect_cols),
        .done      (done),
        .blocked   (blocked),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // cell lies inside the configured grid
    function automatic logic in_grid(input int r, input int c);
        return r >= 0 && r < rows_used && c >= 0 && c < cols_used;
    endfunction

    // size register value after forcing into 1..limit
    function automatic int grid_size(input logic [FLD_W-1:0] v, input int limit);
        int s;
        s = int'(v);
        if (s == 0)
            s = 1;
        if (s > limit)
            s = limit;
        return s;
    endfunction

    // append one expected flag behind the outstanding ones
    function automatic void queue_expected(input logic val);
        pending_blocked = {pending_blocked, val};
    endfunction

    // apply one request to the shadow maps, return the collision flag
    function automatic logic apply_request(input logic [OP_W-1:0] op,
                                           input logic [FLD_W-1:0] ax_f,
                                           input logic [FLD_W-1:0] ay_f,
                                           input logic [FLD_W-1:0] nr_f,
                                           input logic [FLD_W-1:0] nc_f);
        int  ax;
        int  ay;
        int  r;
        int  c;
        logic hit;
        ax  = $signed(ax_f);
        ay  = $signed(ay_f);
        hit = 1'b0;
        case (op)
            OP_CHECK, OP_RESERVE:
            begin
                // row-major walk, the first collision stops it
                for (int dr = 0; dr < int'(nr_f); dr++)
                begin
                    for (int dc = 0; dc < int'(nc_f); dc++)
                    begin
                        r = ay + dr;
                        c = ax + dc;
                        if (!hit)
                        begin
                            if (!in_grid(r, c))
                                hit = 1'b1;
                            else if (op == OP_CHECK)
                                hit = main_cells[r][c];
                            else if (scratch_cells[r][c])
                                hit = 1'b1;
                            else
                                scratch_cells[r][c] = 1'b1;
                        end
                    end
                end
            end
            OP_OCCUPY, OP_VACATE, OP_RELEASE:
            begin
                for (int dr = 0; dr < int'(nr_f); dr++)
                begin
                    for (int dc = 0; dc < int'(nc_f); dc++)
                    begin
                        r = ay + dr;
                        c = ax + dc;
                        if (in_grid(r, c))
                        begin
                            if (op == OP_RELEASE)
                                scratch_cells[r][c] = 1'b0;
                            else
                                main_cells[r][c] = (op == OP_OCCUPY);
                        end
                    end
                end
            end
            OP_COPY:
                scratch_cells = main_cells;
            default:
                ;
        endcase
        return hit;
    endfunction

    // result checking, then config and request tracking
    always @(posedge clk)
    begin : monitor
        logic want;
        logic got;
        if (done)
        begin
            if (pending_blocked.size() == 0)
            begin
                $error("blocked: no request outstanding, actual %0b", blocked);
                fail_count++;
            end
            else
            begin
                want = pending_blocked.pop_front();
                if (blocked !== want)
                begin
                    $error("blocked: expected %0b, actual %0b", want, blocked);
                    fail_count++;
                end
            end
        end
        if (rst_n && cfg_wr_en)
        begin
            if (cfg_addr == REG_GRID_ROWS)
                rows_used = grid_size(cfg_wdata, MAX_ROWS);
            else if (cfg_addr == REG_GRID_COLS)
                cols_used = grid_size(cfg_wdata, MAX_COLS);
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                main_cells[i]    = '0;
                scratch_cells[i] = '0;
            end
        end
        if (rst_n && start && !busy)
        begin
            got = apply_request(req_type, anchor_x, anchor_y, rect_rows, rect_cols);
            queue_expected(pin_valid ? pin_value : got);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // drop start for a random gap in idle mode, then present one request until taken
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [FLD_W-1:0] ax,
                                input logic [FLD_W-1:0] ay,
                                input logic [FLD_W-1:0] nr,
                                input logic [FLD_W-1:0] nc,
                                input logic pinned,
                                input logic pin_val);
        int gap;
        gap = idle_mode ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= op;
        anchor_x  <= ax;
        anchor_y  <= ay;
        rect_rows <= nr;
        rect_cols <= nc;
        pin_valid <= pinned;
        pin_value <= pin_val;
        do
            @(posedge clk);
        while (busy);
    endtask

    // let every outstanding request finish
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_blocked.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write both size registers while the block is idle
    task automatic write_grid(input logic [FLD_W-1:0] rows_v, input logic [FLD_W-1:0] cols_v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_GRID_ROWS;
        cfg_wdata <= rows_v;
        @(posedge clk);
        cfg_addr  <= REG_GRID_COLS;
        cfg_wdata <= cols_v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // one random request, mostly small rectangles near the grid
    task automatic send_random_request;
        int              pick;
        logic [OP_W-1:0] op;
        logic [FLD_W-1:0] ax;
        logic [FLD_W-1:0] ay;
        logic [FLD_W-1:0] nr;
        logic [FLD_W-1:0] nc;
        pick = $urandom_range(0, 99);
        if (pick < 24)
            op = OP_CHECK;
        else if (pick < 44)
            op = OP_OCCUPY;
        else if (pick < 56)
            op = OP_VACATE;
        else if (pick < 63)
            op = OP_COPY;
        else if (pick < 83)
            op = OP_RESERVE;
        else if (pick < 94)
            op = OP_RELEASE;
        else
            op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
        if ($urandom_range(0, 9) < 8)
        begin
            ax = FLD_W'($urandom_range(0, cols_used - 1) - ($urandom_range(0, 5) == 0));
            ay = FLD_W'($urandom_range(0, rows_used - 1) - ($urandom_range(0, 5) == 0));
            nr = FLD_W'($urandom_range(0, rows_used / 2 + 1));
            nc = FLD_W'($urandom_range(0, cols_used / 2 + 1));
        end
        else
        begin
            ax = FLD_W'($urandom());
            ay = FLD_W'($urandom());
            nr = FLD_W'($urandom());
            nc = FLD_W'($urandom());
        end
        send_request(op, ax, ay, nr, nc, 1'b0, 1'b0);
    endtask

    initial
    begin
        logic [FLD_W-1:0] phase_rows [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd0, 5'd0};
        logic [FLD_W-1:0] phase_cols [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd6, 5'd3, 5'd0, 5'd0};
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = OP_CHECK;
        anchor_x    = '0;
        anchor_y    = '0;
        rect_rows   = '0;
        rect_cols   = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_GRID_ROWS;
        cfg_wdata   = '0;
        pin_valid   = 1'b0;
        pin_value   = 1'b0;
        rows_used   = 1;
        cols_used   = 1;
        fail_count  = 0;
        cycle_count = 0;
        idle_mode   = 1'b1;
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            main_cells[i]    = '0;
            scratch_cells[i] = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].regrid)
                write_grid(directed_steps[i].grid_r, directed_steps[i].grid_c);
            send_request(directed_steps[i].op, directed_steps[i].ax, directed_steps[i].ay,
                         directed_steps[i].nr, directed_steps[i].nc,
                         directed_steps[i].pinned, directed_steps[i].pin_val);
        end

        // random phases, each on its own grid size
        for (int p = 0; p < PHASES; p++)
        begin
            if (p >= 6)
                write_grid(FLD_W'($urandom()), FLD_W'($urandom()));
            else
                write_grid(phase_rows[p], phase_cols[p]);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (n % 40 == 0)
                    idle_mode = ($urandom_range(0, 2) != 0);
                send_random_request();
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== grid_rectangle_occupancy_map_unit.f =====
rtl/groc_pkg.sv
rtl/groc_ctrl.sv
rtl/groc_datapath.sv
rtl/grid_rectangle_occupancy_map_unit.sv
test/grid_rectangle_occupancy_map_unit_test.sv
